// File: rtl/core/rsw_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the random shuffle window.
// Used by every module of the block; depends on nothing.
package rsw_pkg;

	// Built window depth and stored record width
	localparam int DEPTH      = 1024;
	localparam int REC_BITS   = 64;

	// Port widths fixed by the interface
	localparam int REC_PORT_W = 64;
	localparam int RND_W      = 32;
	localparam int CAP_W      = 11;
	localparam int CAP_RESET  = 1024;

	// Derived widths: slot address and occupancy count (0..DEPTH)
	localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W      = $clog2(DEPTH + 1);

	// Modulo unit: quotient bits retired per cycle and cycle count
	localparam int MOD_STEPS  = 8;
	localparam int MOD_CYC    = RND_W / MOD_STEPS;
	localparam int MOD_CNT_W  = (MOD_CYC > 1) ? $clog2(MOD_CYC) : 1;

	// Operation codes
	localparam logic FUNC_PUSH = 1'b0;
	localparam logic FUNC_POP  = 1'b1;

	// Request into the modulo unit
	typedef struct packed {
		logic             start;
		logic [RND_W-1:0] dividend;
		logic [CNT_W-1:0] divisor;
	} mod_req_t;

	// Response from the modulo unit
	typedef struct packed {
		logic             done;
		logic [CNT_W-1:0] rem;
	} mod_rsp_t;

endpackage

// File: rtl/core/rsw_mod_unit.sv
`timescale 1ns / 1ps
// Multi-cycle modulo unit: random word modulo a window count.
// Restoring reduction, MOD_STEPS bits per cycle; depends on rsw_pkg.
module rsw_mod_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  rsw_pkg::mod_req_t req,
	output rsw_pkg::mod_rsp_t rsp
);

	logic                          busy_q;
	logic                          done_q;
	logic [rsw_pkg::MOD_CNT_W-1:0] cnt_q;
	logic [rsw_pkg::RND_W-1:0]     dvd_q;
	logic [rsw_pkg::CNT_W-1:0]     div_q;
	logic [rsw_pkg::CNT_W-1:0]     rem_q;
	logic [rsw_pkg::CNT_W-1:0]     rem_nxt;
	logic [rsw_pkg::CNT_W:0]       r;

	// Retire MOD_STEPS dividend bits: shift in, subtract when it fits
	always_comb begin
		r = {1'b0, rem_q};
		for (int i = 0; i < rsw_pkg::MOD_STEPS; i++) begin
			r = {r[rsw_pkg::CNT_W-1:0], dvd_q[rsw_pkg::RND_W-1-i]};
			if (r >= {1'b0, div_q}) begin
				r = r - {1'b0, div_q};
			end
		end
		rem_nxt = r[rsw_pkg::CNT_W-1:0];
	end

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == rsw_pkg::MOD_CNT_W'(rsw_pkg::MOD_CYC - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operands and partial remainder
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			div_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << rsw_pkg::MOD_STEPS;
			rem_q <= rem_nxt;
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

endmodule

// File: rtl/core/rsw_store.sv
`timescale 1ns / 1ps
// Window record store: one write port, two registered read ports.
// Depends on rsw_pkg for depth and record width.
module rsw_store (
	input  logic                         clk,
	input  logic                         we,
	input  logic [rsw_pkg::ADDR_W-1:0]   waddr,
	input  logic [rsw_pkg::REC_BITS-1:0] wdata,
	input  logic                         re,
	input  logic [rsw_pkg::ADDR_W-1:0]   raddr_a,
	input  logic [rsw_pkg::ADDR_W-1:0]   raddr_b,
	output logic [rsw_pkg::REC_BITS-1:0] rdata_a,
	output logic [rsw_pkg::REC_BITS-1:0] rdata_b
);

	logic [rsw_pkg::REC_BITS-1:0] mem [rsw_pkg::DEPTH];

	// Write one entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read picked slot and last occupied slot
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

// File: rtl/core/random_shuffle_window_top.sv
`timescale 1ns / 1ps
// Random shuffle window, top level.
// Uses rsw_pkg, rsw_mod_unit and rsw_store.
// Usage:
//   Input channel (in_valid / in_stall) carries one word: func, record and
//   random_word. func push stores the record while the window is below
//   capacity; once full, it swaps the record with slot random_word mod
//   capacity and returns the old one. func pop drains: it returns slot
//   random_word mod fill and moves the last occupied record into the hole.
//   Output channel (out_valid / out_stall) returns exactly one word per input
//   word: has_record, out_record (zero when none), is_empty.
//   capacity is written through cfg_wr_en / cfg_wr_data; the user must write
//   it only while idle, the block does not enforce this. It resets to 1024,
//   zero acts as 1 and values above the depth act as the depth.
// Sequence:
//   Below-capacity push or empty pop: ST_DONE registers the result, then
//   ST_IDLE takes the next word. Full-window push or pop: the modulo unit runs
//   four 8-bit reduction steps and its done strobe reads the store; ST_WR
//   writes back, ST_DONE registers the result, then ST_IDLE takes the next word.
//   One word is in flight at a time; the next is taken while a result waits.
// Reset clears the fill count and sets the capacity to 1024; store contents
// are not cleared. A stalled receiver holds the output register; the block
// finishes its current word and then waits in its result state.
module random_shuffle_window_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [rsw_pkg::CAP_W-1:0]      cfg_wr_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           func,
	input  logic [rsw_pkg::REC_PORT_W-1:0] record,
	input  logic [rsw_pkg::RND_W-1:0]      random_word,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           has_record,
	output logic [rsw_pkg::REC_PORT_W-1:0] out_record,
	output logic                           is_empty
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIV  = 4'b0010,
		ST_WR   = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t                       state_q;
	logic [rsw_pkg::CAP_W-1:0]    cap_q;
	logic [rsw_pkg::CNT_W-1:0]    fill_q;
	logic [rsw_pkg::CNT_W-1:0]    eff_cap;
	logic                         func_q;
	logic [rsw_pkg::REC_BITS-1:0] rec_q;
	logic [rsw_pkg::ADDR_W-1:0]   slot_q;
	logic                         res_has_q;
	logic [rsw_pkg::REC_BITS-1:0] res_rec_q;
	logic                         res_empty_q;
	logic                         out_valid_q;

	logic                         in_acc;
	logic                         out_free;
	logic                         fill_lt_cap;
	logic                         fill_zero;
	logic                         fast_path;
	logic                         fill_push;
	rsw_pkg::mod_req_t            mod_req;
	rsw_pkg::mod_rsp_t            mod_rsp;

	logic                         mem_we;
	logic [rsw_pkg::ADDR_W-1:0]   mem_waddr;
	logic [rsw_pkg::REC_BITS-1:0] mem_wdata;
	logic                         mem_re;
	logic [rsw_pkg::ADDR_W-1:0]   mem_raddr_b;
	logic [rsw_pkg::REC_BITS-1:0] mem_rdata_a;
	logic [rsw_pkg::REC_BITS-1:0] mem_rdata_b;

	// Clamp the configured capacity to 1..DEPTH
	always_comb begin
		if (cap_q == '0) begin
			eff_cap = rsw_pkg::CNT_W'(1);
		end else if (32'(cap_q) > 32'(rsw_pkg::DEPTH)) begin
			eff_cap = rsw_pkg::CNT_W'(rsw_pkg::DEPTH);
		end else begin
			eff_cap = rsw_pkg::CNT_W'(cap_q);
		end
	end

	// Handshake and path selection
	assign in_stall    = (state_q != ST_IDLE);
	assign in_acc      = in_valid && (state_q == ST_IDLE);
	assign out_free    = !out_valid_q || !out_stall;
	assign fill_lt_cap = (fill_q < eff_cap);
	assign fill_zero   = (fill_q == '0);
	assign fill_push   = (func == rsw_pkg::FUNC_PUSH) && fill_lt_cap;
	assign fast_path   = fill_push || ((func == rsw_pkg::FUNC_POP) && fill_zero);

	// Start the slot reduction for swap pushes and non-empty pops
	assign mod_req.start    = in_acc && !fast_path;
	assign mod_req.dividend = random_word;
	assign mod_req.divisor  = (func == rsw_pkg::FUNC_POP) ? fill_q : eff_cap;

	rsw_mod_unit u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mod_req),
		.rsp    (mod_rsp)
	);

	// Store port control: fill write at accept, swap or move write in ST_WR
	assign mem_we      = (in_acc && fill_push) || (state_q == ST_WR);
	assign mem_waddr   = (state_q == ST_WR) ? slot_q : fill_q[rsw_pkg::ADDR_W-1:0];
	assign mem_re      = (state_q == ST_DIV) && mod_rsp.done;
	assign mem_raddr_b = rsw_pkg::ADDR_W'(fill_q - rsw_pkg::CNT_W'(1));

	always_comb begin
		if (state_q == ST_WR) begin
			mem_wdata = (func_q == rsw_pkg::FUNC_POP) ? mem_rdata_b : rec_q;
		end else begin
			mem_wdata = record[rsw_pkg::REC_BITS-1:0];
		end
	end

	rsw_store u_store (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.re      (mem_re),
		.raddr_a (mod_rsp.rem[rsw_pkg::ADDR_W-1:0]),
		.raddr_b (mem_raddr_b),
		.rdata_a (mem_rdata_a),
		.rdata_b (mem_rdata_b)
	);

	// Sequencer, fill count, capacity and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			cap_q       <= rsw_pkg::CAP_W'(rsw_pkg::CAP_RESET);
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				cap_q <= cfg_wr_data;
			end
			// Raise valid on a finished word, drop it once taken
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (fill_push) begin
							fill_q <= fill_q + 1'b1;
						end
						state_q <= fast_path ? ST_DONE : ST_DIV;
					end
				end
				ST_DIV: begin
					if (mod_rsp.done) begin
						state_q <= ST_WR;
					end
				end
				ST_WR: begin
					if (func_q == rsw_pkg::FUNC_POP) begin
						fill_q <= fill_q - 1'b1;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold the accepted word and form its result
	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_q      <= func;
			rec_q       <= record[rsw_pkg::REC_BITS-1:0];
			res_has_q   <= 1'b0;
			res_rec_q   <= '0;
			res_empty_q <= (func == rsw_pkg::FUNC_POP);
		end
		if (mem_re) begin
			slot_q <= mod_rsp.rem[rsw_pkg::ADDR_W-1:0];
		end
		if (state_q == ST_WR) begin
			res_has_q   <= 1'b1;
			res_rec_q   <= mem_rdata_a;
			res_empty_q <= (func_q == rsw_pkg::FUNC_POP) &&
			               (fill_q == rsw_pkg::CNT_W'(1));
		end
		if ((state_q == ST_DONE) && out_free) begin
			has_record <= res_has_q;
			out_record <= rsw_pkg::REC_PORT_W'(res_rec_q);
			is_empty   <= res_empty_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: rtl/core/rsw_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the random shuffle window, bound to its top level.
// Depends on rsw_pkg for port widths.
module rsw_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic                           has_record,
	input logic [rsw_pkg::REC_PORT_W-1:0] out_record,
	input logic                           is_empty
);

	// One word in flight: an accepted word blocks the input next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while previous word in flight");

	// A fresh result only comes out of a word in flight
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared with no word in flight");

	// No record emitted means a zero record
	a_zero_when_none: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_record |-> out_record == '0)
		else $error("nonzero record without has_record");

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_record) &&
		$stable(has_record) && $stable(is_empty))
		else $error("stalled result changed");

endmodule

bind random_shuffle_window_top rsw_checker u_rsw_checker (.*);
